// ----- sv/sha_pkg.sv -----
package sha_pkg;

	localparam int DIGEST_WORDS = 8;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic       init;      // load IV, clear counts
		logic       wr_byte;   // store byte at fill position
		logic       pad_byte;  // write pad value at fill position
		logic [7:0] pad_val;
		logic       mark_len;  // latch fill position as the message tail
		logic       wr_len;    // write length into bytes 56..63
		logic       start;     // load working vars, schedule from buffer
		logic       round;     // one round
		logic       fold;      // add working vars into chaining value
		logic       inc_blk;   // block counter +1
		logic       adv_fill;  // fill position +1
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
	} sha_sts_t;

	function automatic logic [31:0] iv_word(input logic m224, input logic [2:0] i);
		logic [31:0] r;
		case ({m224, i})
			4'h0: r = 32'h6a09e667; 4'h1: r = 32'hbb67ae85;
			4'h2: r = 32'h3c6ef372; 4'h3: r = 32'ha54ff53a;
			4'h4: r = 32'h510e527f; 4'h5: r = 32'h9b05688c;
			4'h6: r = 32'h1f83d9ab; 4'h7: r = 32'h5be0cd19;
			4'h8: r = 32'hc1059ed8; 4'h9: r = 32'h367cd507;
			4'ha: r = 32'h3070dd17; 4'hb: r = 32'hf70e5939;
			4'hc: r = 32'hffc00b31; 4'hd: r = 32'h68581511;
			4'he: r = 32'h64f98fa7; default: r = 32'hbefa4fa4;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

endpackage

// ----- sv/sha_datapath.sv -----
module sha_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode_sha224,
	input  logic [7:0]        data_byte,
	input  sha_pkg::sha_cmd_t cmd,
	input  logic [2:0]        rd_idx,
	output sha_pkg::sha_sts_t sts,
	output logic [31:0]       cv_word
);
	import sha_pkg::*;

	logic [31:0] buf_q [16];
	logic [31:0] cv_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  fill_q;
	logic [5:0]  len_q;
	logic [54:0] blk_q;
	logic [5:0]  rnd_q;

	logic [63:0] bits;
	logic [4:0]  lane;
	logic [31:0] x2, x15, s0, s1, wnew, wi, e, a, t1, t2, ch, maj, se, sa;

	assign bits = {blk_q, len_q, 3'b000};
	// big-endian: byte 0 of a word sits in bits 31:24
	assign lane = {~fill_q[1:0], 3'b000};
	assign sts.fill = fill_q;
	assign sts.round_last = (rnd_q == 6'd63);
	assign cv_word = cv_q[rd_idx];

	always_comb begin
		x2   = w_q[14];
		x15  = w_q[1];
		s1   = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
		s0   = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
		wnew = s1 + w_q[9] + s0 + w_q[0];
		// window slides each round; w_q[0] is this round's word for the first 16
		wi   = (rnd_q < 6'd16) ? w_q[0] : wnew;
		e    = v_q[4];
		a    = v_q[0];
		se   = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		sa   = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		ch   = (e & v_q[5]) ^ (~e & v_q[6]);
		maj  = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1   = v_q[7] + se + ch + round_k(rnd_q) + wi;
		t2   = sa + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			blk_q  <= '0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(1'b0, 3'(i));
		end else begin
			if (cmd.init) begin
				fill_q <= '0;
				blk_q  <= '0;
				for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(mode_sha224, 3'(i));
			end else begin
				if (cmd.adv_fill) fill_q <= fill_q + 6'd1;
				if (cmd.inc_blk) blk_q <= blk_q + 55'd1;
				if (cmd.fold)
					for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
			end
			if (cmd.mark_len) len_q <= fill_q;
			if (cmd.start) rnd_q <= '0;
			else if (cmd.round) rnd_q <= rnd_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) buf_q[fill_q[5:2]][lane +: 8] <= data_byte;
		if (cmd.pad_byte) buf_q[fill_q[5:2]][lane +: 8] <= cmd.pad_val;
		if (cmd.wr_len) begin
			buf_q[14] <= bits[63:32];
			buf_q[15] <= bits[31:0];
		end
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= buf_q[i];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wi;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

// ----- sv/sha_ctrl.sv -----
module sha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mode_sha224,
	input  logic               cfg_wr,
	input  logic               in_fire,
	input  logic               in_func,
	output logic               in_rdy,
	input  sha_pkg::sha_sts_t  sts,
	output sha_pkg::sha_cmd_t  cmd,
	output logic [2:0]         rd_idx,
	input  logic [31:0]        cv_word,
	output sha_pkg::out_beat_t out_beat,
	output logic               out_vld,
	input  logic               out_rdy
);
	import sha_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PAD, S_LEN, S_START, S_ROUND, S_FOLD, S_EMIT
	} state_t;

	state_t     state_q;
	logic       fin_q;     // compressing as part of finish
	logic       last_q;    // the final compression of finish
	logic [2:0] idx_q;

	assign in_rdy = (state_q == S_IDLE);
	assign rd_idx = idx_q;

	always_comb begin
		cmd = '0;
		cmd.init = cfg_wr;
		case (state_q)
			S_IDLE: begin
				if (in_fire && !in_func) begin
					cmd.wr_byte = 1'b1;
					cmd.adv_fill = 1'b1;
				end
				if (in_fire && in_func) begin
					cmd.pad_byte = 1'b1;
					cmd.pad_val = 8'h80;
					cmd.mark_len = 1'b1;
					cmd.adv_fill = 1'b1;
				end
			end
			S_PAD: begin
				cmd.pad_byte = 1'b1;
				cmd.adv_fill = 1'b1;
			end
			S_LEN:   cmd.wr_len = 1'b1;
			S_START: cmd.start = 1'b1;
			S_ROUND: cmd.round = 1'b1;
			S_FOLD: begin
				cmd.fold = 1'b1;
				cmd.inc_blk = !fin_q;
			end
			S_EMIT: cmd.init = cfg_wr || (out_vld && out_rdy && out_beat.last_word);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
			last_q  <= 1'b0;
			idx_q   <= '0;
			out_vld <= 1'b0;
			out_beat <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					if (!in_func) begin
						if (sts.fill == 6'd63) begin
							fin_q <= 1'b0;
							state_q <= S_START;
						end
					end else begin
						fin_q <= 1'b1;
						// the 0x80 took byte fill; length fits if it was <= 55
						last_q <= (sts.fill <= 6'd55);
						state_q <= (sts.fill == 6'd55) ? S_LEN
							: (sts.fill == 6'd63) ? S_START : S_PAD;
					end
				end
				S_PAD: begin
					if (last_q && sts.fill == 6'd55) state_q <= S_LEN;
					else if (!last_q && sts.fill == 6'd63) state_q <= S_START;
				end
				S_LEN:   state_q <= S_START;
				S_START: state_q <= S_ROUND;
				S_ROUND: if (sts.round_last) state_q <= S_FOLD;
				S_FOLD: begin
					if (!fin_q) state_q <= S_IDLE;
					else if (!last_q) begin
						last_q <= 1'b1;
						state_q <= S_PAD;  // fill wrapped to 0, pad to 55
					end else begin
						idx_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_vld) begin
						out_vld <= 1'b1;
						out_beat.digest_word <= cv_word;
						out_beat.word_index <= idx_q;
						out_beat.last_word <= mode_sha224 ? (idx_q == 3'(DIGEST_WORDS - 2))
							: (idx_q == 3'(DIGEST_WORDS - 1));
						idx_q <= idx_q + 3'd1;
					end else if (out_rdy) begin
						out_vld <= 1'b0;
						if (out_beat.last_word) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/sha256_sha224_hash.sv -----
// channel | dir | handshake              | payload
// cfg     | in  | cfg_valid / cfg_ready  | cfg_data (mode_sha224)
// in      | in  | in_valid / in_ready    | in_data (func, data_byte)
// out     | out | out_valid / out_ready  | out_data (digest_word, word_index, last_word)
// A byte that fills the block starts a compression (load, 64 rounds on one
// shared round unit, fold). Finish pads one byte a cycle up to byte 55 (from
// past 55: up to 63, compress, then from 0 to 55), compresses, then emits the
// digest one word at a time. Reset loads the SHA-256 IV. Input is held off
// while padding, while a block compresses or the digest drains; out_ready low stalls the digest.
module sha256_sha224_hash (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  sha_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sha_pkg::out_beat_t out_data
);
	import sha_pkg::*;

	logic       mode_q;
	logic       cfg_wr;
	sha_cmd_t   cmd;
	sha_sts_t   sts;
	logic [2:0] rd_idx;
	logic [31:0] cv_word;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (cfg_wr) mode_q <= cfg_data;
	end

	// datapath init uses the value being written
	sha_datapath u_dp (
		.clk, .arst_n,
		.mode_sha224(cfg_wr ? cfg_data : mode_q),
		.data_byte(in_data.data_byte),
		.cmd, .rd_idx, .sts, .cv_word
	);

	sha_ctrl u_ctrl (
		.clk, .arst_n,
		.mode_sha224(mode_q),
		.cfg_wr,
		.in_fire(in_valid && in_ready),
		.in_func(in_data.func),
		.in_rdy(in_ready),
		.sts, .cmd, .rd_idx, .cv_word,
		.out_beat(out_data),
		.out_vld(out_valid),
		.out_rdy(out_ready)
	);

endmodule

// ----- verif/sha256_sha224_hash_tb.sv -----
`timescale 1ns / 1ps

module sha256_sha224_hash_tb;
	import sha_pkg::*;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_beat_t out_data;

	sha256_sha224_hash u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #6 clk = ~clk;

	// hash state mirrored from the block
	logic        mode224;
	logic [31:0] chain [8];
	logic [7:0]  blk_buf [64];
	logic [5:0]  fill;
	logic [54:0] blk_cnt;

	out_beat_t digest_q [$];
	int errors = 0;
	int words_seen = 0;
	int msgs_done = 0;
	int idle_cycles = 0;
	bit hold_rx = 1'b0;
	bit rx_random = 1'b1;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void start_msg();
		for (int i = 0; i < 8; i++) begin
			chain[i] = mode224 ? 32'hc1059ed8 : 32'h0;
		end
		if (mode224) begin
			chain = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
				32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
		end else begin
			chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		end
		fill = '0;
		blk_cnt = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] kc [64];
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		kc = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		for (int i = 0; i < 16; i++) begin
			w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
		end
		for (int i = 16; i < 64; i++) begin
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
			chain[4], chain[5], chain[6], chain[7]};
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ kc[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endfunction

	// advance the mirror by one accepted beat, queue digest words on finish
	function automatic void hash_beat(input in_beat_t beat);
		logic [63:0] bits;
		int n, words;
		out_beat_t ow;
		if (beat.func == FUNC_APPEND) begin
			blk_buf[fill] = beat.data_byte;
			fill = fill + 6'd1;
			if (fill == 0) begin
				compress_block();
				blk_cnt = blk_cnt + 55'd1;
			end
			return;
		end
		n = fill;
		blk_buf[n] = 8'h80;
		for (int i = n + 1; i < 64; i++) blk_buf[i] = 8'h00;
		if (n > 55) begin
			compress_block();
			for (int i = 0; i < 56; i++) blk_buf[i] = 8'h00;
		end
		bits = {blk_cnt, 9'd0} + (64'(n) << 3);
		for (int i = 0; i < 8; i++) blk_buf[56+i] = bits[63-8*i -: 8];
		compress_block();
		words = mode224 ? 7 : 8;
		for (int i = 0; i < words; i++) begin
			ow.digest_word = chain[i];
			ow.word_index = 3'(i);
			ow.last_word = (i == words - 1);
			digest_q.push_back(ow);
		end
		start_msg();
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		errors++;
		$display("mismatch %s: got %h, expected %h at %0t", what, got, exp, $realtime);
	endtask

	// predictor runs on accepted input beats
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) hash_beat(in_data);
	end

	// digest checker
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (digest_q.size() == 0) begin
				report("unexpected word", out_data.digest_word, 32'h0);
			end else begin
				e = digest_q.pop_front();
				if (out_data.digest_word !== e.digest_word)
					report("digest_word", out_data.digest_word, e.digest_word);
				if (out_data.word_index !== e.word_index)
					report("word_index", 32'(out_data.word_index), 32'(e.word_index));
				if (out_data.last_word !== e.last_word)
					report("last_word", 32'(out_data.last_word), 32'(e.last_word));
				if (e.last_word) msgs_done++;
			end
		end
	end

	// receiver: random stalls, always ready, or a long hold when requested
	always @(posedge clk) begin
		if (hold_rx) out_ready <= 1'b0;
		else if (!rx_random) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 7) < 5);
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $realtime);
			$display("[sha256_sha224_hash] ERROR");
			$finish;
		end
	end

	bit tx_gaps = 1'b1;

	task automatic send_beat(input logic func, input logic [7:0] b);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 7) : 0;
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= '{func: func, data_byte: b};
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
	endtask

	task automatic send_append(input logic [7:0] b);
		send_beat(FUNC_APPEND, b);
	endtask

	task automatic send_finish();
		send_beat(FUNC_FINISH, 8'($urandom));
	endtask

	task automatic drain();
		while (digest_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode224 = m;
		start_msg();
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) send_append(8'($urandom));
		send_finish();
	endtask

	task automatic test_directed();
		send_finish();                              // empty message
		send_append(8'h61); send_append(8'h62); send_append(8'h63);
		send_finish();                              // "abc"
	endtask

	task automatic test_pad_edges();
		// one full block, then 56 bytes leave no room for the length
		send_message(120);
	endtask

	task automatic test_sha224();
		write_mode(1'b1);
		send_message(3);
	endtask

	task automatic test_mode_discard();
		// a mode write mid-message throws away the partial message
		send_append(8'h11); send_append(8'h22);
		write_mode(1'b0);
		send_finish();
	endtask

	task automatic test_backpressure();
		// receiver held off in its own process while finishes keep coming
		fork
			begin
				hold_rx = 1'b1;
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
			end
			begin
				send_message(1);
				send_finish();
				send_finish();
			end
		join
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 10) begin
			int len;
			len = $urandom_range(0, 3);
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_random = ($urandom_range(0, 3) != 0);
			send_message(len);
			sent += len + 1;
			if ($urandom_range(0, 5) == 0) write_mode(1'($urandom));
		end
		tx_gaps = 1'b1;
		rx_random = 1'b1;
	endtask

	initial begin
		mode224 = 1'b0;
		for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
		start_msg();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pad_edges();
		test_sha224();
		test_mode_discard();
		test_backpressure();
		test_random();
		write_mode(1'b0);
		drain();
		$display("covered %0d digests (%0d words) in both modes, padding edges,",
			msgs_done, words_seen);
		$display("mode writes mid-message and a long output stall");
		if (errors == 0 && digest_q.size() == 0) begin
			$display("[sha256_sha224_hash] OK");
		end else begin
			$display("[sha256_sha224_hash] ERROR");
		end
		$finish;
	end

endmodule
